// ===== hw/rtl/ege_pkg.sv =====
// shared types and constants for the exp-golomb ue(v) decoder
package ege_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RUN_W   = 6;
  localparam int unsigned BIT_W   = 3;

  typedef struct packed {
    logic [BYTE_W-1:0] stream_byte;
    logic              final_byte;
  } ege_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] code_value;
    logic               cut_short;
    logic               prefix_overflow;
    logic               stream_done;
  } ege_result_t;

  function automatic logic [VALUE_W-1:0] code_base(input logic [RUN_W-1:0] zeros);
    logic [VALUE_W:0] one_hot;
    begin
      one_hot = (VALUE_W+1)'(1) << zeros;
      code_base = VALUE_W'(one_hot - (VALUE_W+1)'(1));
    end
  endfunction

endpackage

// ===== hw/rtl/ege_in_queue.sv =====
// two-entry input queue between the byte port and the decode core
module ege_in_queue
  import ege_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ege_item_t push_item,
  output logic      not_full,
  input  logic      pop,
  output logic      not_empty,
  output ege_item_t head_item
);

  ege_item_t   slot_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        do_push;
  logic        do_pop;

  assign not_full  = (count_r != 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head_item = slot_r[rd_ptr_r];
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

// ===== hw/rtl/ege_bit_core.sv =====
// bit-serial ue(v) decode core with result holding and output register
module ege_bit_core
  import ege_pkg::*;
#(
  parameter int unsigned MAX_PREFIX = 31
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  ege_item_t          q_item,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [VALUE_W-1:0] out_tdata,
  output logic [2:0]         out_tuser,
  output logic               out_tlast
);

  logic               busy_r, busy_nxt;
  logic [BYTE_W-1:0]  shift_r, shift_nxt;
  logic [BIT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic               final_r, final_nxt;
  logic               in_suffix_r, in_suffix_nxt;
  logic [RUN_W-1:0]   zero_run_r, zero_run_nxt;
  logic [RUN_W-1:0]   suffix_rem_r, suffix_rem_nxt;
  logic [VALUE_W-1:0] suffix_bits_r, suffix_bits_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic               pend_closed_r, pend_closed_nxt;
  ege_result_t        pend_r, pend_nxt;
  logic               out_v_r, out_v_nxt;
  ege_result_t        out_r, out_nxt;
  logic               out_last_r, out_last_nxt;

  logic               out_free;
  logic               step;
  logic               last_bit;
  logic               cur_bit;
  logic               new_v;
  ege_result_t        new_res;
  logic               move;

  assign out_free = !out_v_r || out_tready;
  assign step     = busy_r && (!pend_v_r || out_free);
  assign last_bit = step && (bit_cnt_r == '0);
  assign cur_bit  = shift_r[BYTE_W-1];

  always_comb begin
    in_suffix_nxt   = in_suffix_r;
    zero_run_nxt    = zero_run_r;
    suffix_rem_nxt  = suffix_rem_r;
    suffix_bits_nxt = suffix_bits_r;
    new_v           = 1'b0;
    new_res         = '{code_value: '0, cut_short: 1'b0, prefix_overflow: 1'b0,
                        stream_done: final_r};
    if (step) begin
      if (in_suffix_r) begin
        suffix_bits_nxt = {suffix_bits_r[VALUE_W-2:0], cur_bit};
        suffix_rem_nxt  = suffix_rem_r - RUN_W'(1);
        if (suffix_rem_r == RUN_W'(1)) begin
          new_v              = 1'b1;
          new_res.code_value = code_base(zero_run_r) + suffix_bits_nxt;
          in_suffix_nxt      = 1'b0;
          zero_run_nxt       = '0;
          suffix_rem_nxt     = '0;
          suffix_bits_nxt    = '0;
        end
      end else if (!cur_bit) begin
        zero_run_nxt = zero_run_r + RUN_W'(1);
        if (zero_run_nxt > RUN_W'(MAX_PREFIX)) begin
          new_v                   = 1'b1;
          new_res.prefix_overflow = 1'b1;
          zero_run_nxt            = '0;
        end
      end else if (zero_run_r == '0) begin
        new_v = 1'b1;
      end else begin
        in_suffix_nxt   = 1'b1;
        suffix_rem_nxt  = zero_run_r;
        suffix_bits_nxt = '0;
      end
      if (last_bit && final_r) begin
        if (!new_v && (in_suffix_nxt || zero_run_nxt != '0)) begin
          new_v              = 1'b1;
          new_res.cut_short  = 1'b1;
          new_res.code_value = code_base(zero_run_nxt) + suffix_bits_nxt;
        end
        in_suffix_nxt   = 1'b0;
        zero_run_nxt    = '0;
        suffix_rem_nxt  = '0;
        suffix_bits_nxt = '0;
      end
    end
  end

  always_comb begin
    busy_nxt    = busy_r;
    shift_nxt   = shift_r;
    bit_cnt_nxt = bit_cnt_r;
    final_nxt   = final_r;
    q_pop       = q_not_empty && (!busy_r || last_bit);
    if (step) begin
      shift_nxt   = {shift_r[BYTE_W-2:0], 1'b0};
      bit_cnt_nxt = bit_cnt_r - BIT_W'(1);
      if (last_bit) busy_nxt = 1'b0;
    end
    if (q_pop) begin
      busy_nxt    = 1'b1;
      shift_nxt   = q_item.stream_byte;
      bit_cnt_nxt = BIT_W'(BYTE_W - 1);
      final_nxt   = q_item.final_byte;
    end
  end

  always_comb begin
    move            = pend_v_r && out_free && (pend_closed_r || new_v || last_bit);
    pend_v_nxt      = pend_v_r;
    pend_closed_nxt = pend_closed_r;
    pend_nxt        = pend_r;
    out_v_nxt       = out_v_r && !out_tready;
    out_nxt         = out_r;
    out_last_nxt    = out_last_r;
    if (move) begin
      out_v_nxt    = 1'b1;
      out_nxt      = pend_r;
      out_last_nxt = pend_closed_r || (last_bit && !new_v);
    end
    if (new_v) begin
      pend_v_nxt      = 1'b1;
      pend_closed_nxt = last_bit;
      pend_nxt        = new_res;
    end else if (move) begin
      pend_v_nxt      = 1'b0;
      pend_closed_nxt = 1'b0;
    end else if (last_bit && pend_v_r) begin
      pend_closed_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      in_suffix_r   <= 1'b0;
      zero_run_r    <= '0;
      suffix_rem_r  <= '0;
      suffix_bits_r <= '0;
      pend_v_r      <= 1'b0;
      pend_closed_r <= 1'b0;
      out_v_r       <= 1'b0;
    end else begin
      busy_r        <= busy_nxt;
      in_suffix_r   <= in_suffix_nxt;
      zero_run_r    <= zero_run_nxt;
      suffix_rem_r  <= suffix_rem_nxt;
      suffix_bits_r <= suffix_bits_nxt;
      pend_v_r      <= pend_v_nxt;
      pend_closed_r <= pend_closed_nxt;
      out_v_r       <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r    <= shift_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    final_r    <= final_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r.code_value;
  assign out_tuser  = {out_r.stream_done, out_r.prefix_overflow, out_r.cut_short};
  assign out_tlast  = out_last_r;

  a_ovf_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.prefix_overflow |-> out_r.code_value == '0)
    else $error("overflow result with nonzero value");

  a_cut_ends_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.cut_short |-> out_r.stream_done && out_last_r && !out_r.prefix_overflow)
    else $error("truncated result not closing the stream");

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    zero_run_r <= RUN_W'(MAX_PREFIX))
    else $error("zero run beyond prefix limit");

  a_suffix_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_suffix_r |-> suffix_rem_r != '0 && suffix_rem_r <= zero_run_r)
    else $error("suffix count out of range");

  a_state_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    last_bit && final_r |=> !in_suffix_r && zero_run_r == '0)
    else $error("state not cleared after final byte");

endmodule

// ===== hw/rtl/exp_golomb_ue_decoder_top.sv =====
// top level of the unsigned exp-golomb ue(v) stream decoder
// Bytes enter on the in_ stream and are decoded most significant bit first by a core
// that consumes one bit per clock while no held result waits on a stalled output;
// a two-entry queue lets the next bytes be taken while the core works, and results
// leave through a one-deep holding stage plus an output register, one per cycle at
// most. A result waits in the holding stage until the next result of its byte or the
// byte's last bit is decoded, because only then is its out_tlast known, and it waits
// longer while out_tready is low; out_tlast marks the last result of each byte, so a
// byte that completes no code shows no output at all.
module exp_golomb_ue_decoder_top
  import ege_pkg::*;
#(
  parameter int unsigned MAX_PREFIX = 31
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [BYTE_W-1:0]  in_tdata,   // [7:0] stream_byte
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [VALUE_W-1:0] out_tdata,  // [31:0] code_value
  output logic [2:0]         out_tuser,  // [0] cut_short, [1] prefix_overflow, [2] stream_done
  output logic               out_tlast
);

  ege_item_t in_item;
  ege_item_t head_item;
  logic      q_not_empty;
  logic      q_pop;

  assign in_item = '{stream_byte: in_tdata, final_byte: in_tlast};

  ege_in_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_item (in_item),
    .not_full  (in_tready),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  ege_bit_core #(
    .MAX_PREFIX (MAX_PREFIX)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_item      (head_item),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule
